// ===== rtl/lrupr_pkg.sv =====
// Package for the LRU page-frame tracker.
// Holds the item types, field widths and configuration constants.
// Depends on nothing; used by every module of the block.
package lrupr_pkg;

  localparam int PAGE_BITS   = 16;
  localparam int FRAMES_DEF  = 8;
  localparam int CFG_W       = 4;
  localparam int FIDX_W      = 3;
  localparam int COUNT_W     = 16;

  localparam logic [CFG_W-1:0]   CFG_RESET = CFG_W'(8);
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  typedef struct packed {
    logic [PAGE_BITS-1:0] page;
    logic                 last_ref;
  } in_t;

  typedef struct packed {
    logic                 hit;
    logic [FIDX_W-1:0]    frame_index;
    logic                 evicted_valid;
    logic [PAGE_BITS-1:0] evicted_page;
    logic [COUNT_W-1:0]   fault_count;
  } out_t;

endpackage

// ===== rtl/lru_page_replacement.sv =====
// Top level of the LRU page-frame tracker: configuration register,
// input register and output register around the frame store.
// Depends on lrupr_pkg and lrupr_store.
//
// Usage: each input item carries one page reference and a last-reference
// flag on a valid/ready channel. Each accepted item yields exactly one
// result item on the output valid/ready channel: hit flag, frame used,
// evicted page if any and the saturating fault count of the current string.
// An item marked last clears all frames and the count after its result.
// The frame count register is written by cfg_we_i and cfg_data_i. The user
// must write it only while the block is idle; the block does not enforce
// this. Zero acts as one and values above FRAMES act as FRAMES.
// Throughput: one item per cycle while results are taken, as the tag compare
// and age-rank update in the frame store are combinational.
// Reset empties all frames, clears the count and sets the frame count to 8.
// While the receiver stalls, the input register still takes one more item;
// after that in_ready_o stays low until the result is taken.
module lru_page_replacement #(
  parameter int FRAMES = lrupr_pkg::FRAMES_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  lrupr_pkg::in_t             in_data_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output lrupr_pkg::out_t            out_data_o,
  input  logic                       cfg_we_i,
  input  logic [lrupr_pkg::CFG_W-1:0] cfg_data_i
);
  import lrupr_pkg::*;

  logic [CFG_W-1:0]  cfg_q;
  logic              in_valid_q;
  in_t               in_data_q;
  logic              out_valid_q;
  out_t              out_data_q;
  logic              adv;
  logic [FRAMES-1:0] active;
  int                n_use;
  out_t              res;

  assign adv        = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || adv;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  always_comb begin
    if (cfg_q == '0) begin
      n_use = 1;
    end else if (int'(cfg_q) > FRAMES) begin
      n_use = FRAMES;
    end else begin
      n_use = int'(cfg_q);
    end
    for (int i = 0; i < FRAMES; i++) begin
      active[i] = (i < n_use);
    end
  end

  lrupr_store #(
    .FRAMES (FRAMES)
  ) u_store (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (adv),
    .item_i   (in_data_q),
    .active_i (active),
    .res_o    (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q       <= CFG_RESET;
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        cfg_q <= cfg_data_i;
      end
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (adv) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_data_q <= in_data_i;
    end
    if (adv) begin
      out_data_q <= res;
    end
  end

`ifndef SYNTHESIS
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !adv |=> in_valid_q && $stable(in_data_q))
    else $error("pending item lost from the input register");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_ready_i |=> out_valid_q && $stable(out_data_q))
    else $error("stalled result changed or dropped");
  a_adv_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv |=> out_valid_q)
    else $error("processed item produced no result");
`endif

endmodule

// ===== rtl/lrupr_store.sv =====
// Frame store of the LRU page-frame tracker: pages, valid bits, age ranks
// and the fault counter, with the combinational lookup and registered update.
// Depends on lrupr_pkg.
module lrupr_store #(
  parameter int FRAMES = lrupr_pkg::FRAMES_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               step_i,
  input  lrupr_pkg::in_t     item_i,
  input  logic [FRAMES-1:0]  active_i,
  output lrupr_pkg::out_t    res_o
);
  import lrupr_pkg::*;

  localparam int IdxW = (FRAMES > 1) ? $clog2(FRAMES) : 1;

  logic [PAGE_BITS-1:0] page_q [FRAMES];
  logic [FRAMES-1:0]    valid_q;
  logic [IdxW-1:0]      rank_q  [FRAMES];
  logic [COUNT_W-1:0]   fault_q;

  logic [FRAMES-1:0]    match;
  logic [FRAMES-1:0]    empty;
  logic [FRAMES-1:0]    is_max;
  logic [IdxW-1:0]      hit_idx;
  logic [IdxW-1:0]      empty_idx;
  logic [IdxW-1:0]      victim_idx;
  logic                 hit;
  logic                 any_empty;
  logic [IdxW-1:0]      f;
  logic [IdxW-1:0]      rank_f;
  logic                 age_all;
  logic [COUNT_W-1:0]   fault_d;
  logic [31:0]          f_wide;
  logic [IdxW-1:0]      rank_d  [FRAMES];

  always_comb begin
    for (int i = 0; i < FRAMES; i++) begin
      match[i] = active_i[i] && valid_q[i] && (page_q[i] == item_i.page);
      empty[i] = active_i[i] && !valid_q[i];
      is_max[i] = active_i[i];
      for (int j = 0; j < FRAMES; j++) begin
        if (active_i[j] && (rank_q[j] > rank_q[i])) begin
          is_max[i] = 1'b0;
        end
      end
    end
    hit_idx    = '0;
    empty_idx  = '0;
    victim_idx = '0;
    for (int i = FRAMES - 1; i >= 0; i--) begin
      if (match[i]) begin
        hit_idx = IdxW'(i);
      end
      if (empty[i]) begin
        empty_idx = IdxW'(i);
      end
      if (is_max[i]) begin
        victim_idx = IdxW'(i);
      end
    end
    hit       = |match;
    any_empty = |empty;
    age_all   = !hit && any_empty;
    if (hit) begin
      f = hit_idx;
    end else if (any_empty) begin
      f = empty_idx;
    end else begin
      f = victim_idx;
    end
    rank_f = rank_q[f];
    for (int i = 0; i < FRAMES; i++) begin
      rank_d[i] = rank_q[i];
      if (IdxW'(i) == f) begin
        rank_d[i] = '0;
      end else if (valid_q[i] && (age_all || (rank_q[i] < rank_f))) begin
        rank_d[i] = rank_q[i] + 1'b1;
      end
    end
    if (!hit && (fault_q != COUNT_MAX)) begin
      fault_d = fault_q + 1'b1;
    end else begin
      fault_d = fault_q;
    end
    f_wide = 32'(f);
    res_o.hit           = hit;
    res_o.frame_index   = f_wide[FIDX_W-1:0];
    res_o.evicted_valid = !hit && !any_empty;
    res_o.evicted_page  = (!hit && !any_empty) ? page_q[f] : '0;
    res_o.fault_count   = fault_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      fault_q <= '0;
      for (int i = 0; i < FRAMES; i++) begin
        rank_q[i] <= '0;
      end
    end else if (step_i) begin
      if (item_i.last_ref) begin
        valid_q <= '0;
        fault_q <= '0;
        for (int i = 0; i < FRAMES; i++) begin
          rank_q[i] <= '0;
        end
      end else begin
        if (!hit) begin
          valid_q[f] <= 1'b1;
        end
        fault_q <= fault_d;
        for (int i = 0; i < FRAMES; i++) begin
          rank_q[i] <= rank_d[i];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_i && !hit) begin
      page_q[f] <= item_i.page;
    end
  end

`ifndef SYNTHESIS
  a_valid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !step_i |=> $stable(valid_q))
    else $error("frame valid bits changed without an item");
  a_last_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && item_i.last_ref |=> (valid_q == '0) && (fault_q == '0))
    else $error("store not cleared after the last item");
  a_used_newest: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && !item_i.last_ref |=> valid_q[$past(f)] && (rank_q[$past(f)] == '0))
    else $error("used frame is not valid and most recent");
  a_hit_no_evict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && hit |-> !res_o.evicted_valid && (res_o.fault_count == fault_q))
    else $error("hit item reports an eviction or a new fault");
`endif

endmodule
